FILE: hw/rtl/selective_repeat_sender_window_defines.svh
// ----------------------------------------------------------------------------
// Selective-repeat sender window: assertion macros
// Clocked assertion wrappers shared by the window RTL. They expect signals
// named clk and rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge while the block is out of reset.
`define SRSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define SRSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRSW_ASSERT(lbl, prop, msg)
`define SRSW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/srsw_pkg.sv
// ----------------------------------------------------------------------------
// Selective-repeat sender window: shared definitions
// Defaults, field widths, action and status codes and the command format
// passed from the front end to the window engine.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  localparam int WINDOW_DEPTH_DEF = 8;
  localparam int PAYLOAD_MAX_DEF  = 1024;
  localparam int SEQ_SPACE_DEF    = 65536;

  localparam int SEQ_PORT_W  = 16;
  localparam int SLOT_PORT_W = 3;
  localparam int PLEN_PORT_W = 11;
  localparam int CFG_W       = 32;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic ACTION_SEND = 1'b0;
  localparam logic ACTION_ACK  = 1'b1;

  localparam logic [1:0] ACK_NONE    = 2'd0;
  localparam logic [1:0] ACK_NEW     = 2'd1;
  localparam logic [1:0] ACK_DUP     = 2'd2;
  localparam logic [1:0] ACK_OUTSIDE = 2'd3;

  typedef enum logic [1:0] {
    CMD_REQ,
    CMD_ACK,
    CMD_ACK_FAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [SEQ_PORT_W-1:0]   ack;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/srsw_front.sv
// ----------------------------------------------------------------------------
// Selective-repeat sender window: front end
// Registers incoming transfers and sorts them into send requests, acks and
// acks whose number lies beyond the sequence space.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_front #(
  parameter int SEQ_SPACE = srsw_pkg::SEQ_SPACE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  input  wire logic [srsw_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              in_tuser,
  output      logic                              cmd_vld,
  output      srsw_pkg::cmd_t                    cmd,
  input  wire logic                              cmd_rdy
);

  localparam int RANGE_W = srsw_pkg::IN_TDATA_W + 1;

  logic           vld_r;
  srsw_pkg::cmd_t cmd_r;
  srsw_pkg::cmd_t cmd_nxt;
  logic           ack_far;

  assign in_tready = !vld_r || cmd_rdy;
  assign cmd_vld   = vld_r;
  assign cmd       = cmd_r;

  always_comb begin
    ack_far     = {1'b0, in_tdata} >= RANGE_W'(SEQ_SPACE);
    cmd_nxt.ack = in_tdata;
    if (in_tuser == srsw_pkg::ACTION_SEND) begin
      cmd_nxt.kind = srsw_pkg::CMD_REQ;
    end else if (ack_far) begin
      cmd_nxt.kind = srsw_pkg::CMD_ACK_FAR;
    end else begin
      cmd_nxt.kind = srsw_pkg::CMD_ACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
      if (in_tvalid) begin
        cmd_r <= cmd_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srsw_queue.sv
// ----------------------------------------------------------------------------
// Selective-repeat sender window: command queue
// Short first-in first-out buffer between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_vld,
  output      logic           push_rdy,
  input  wire srsw_pkg::cmd_t push_cmd,
  output      logic           pop_vld,
  input  wire logic           pop_rdy,
  output      srsw_pkg::cmd_t pop_cmd
);

  localparam logic [srsw_pkg::QPTR_W-1:0] PTR_LAST =
    srsw_pkg::QPTR_W'(srsw_pkg::QUEUE_DEPTH - 1);
  localparam logic [srsw_pkg::QCNT_W-1:0] CNT_FULL =
    srsw_pkg::QCNT_W'(srsw_pkg::QUEUE_DEPTH);

  srsw_pkg::cmd_t                entry_r [srsw_pkg::QUEUE_DEPTH];
  logic [srsw_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [srsw_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [srsw_pkg::QCNT_W-1:0]   cnt_r;
  logic                          do_push;
  logic                          do_pop;

  assign push_rdy = cnt_r != CNT_FULL;
  assign pop_vld  = cnt_r != '0;
  assign pop_cmd  = entry_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        entry_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srsw_engine.sv
// ----------------------------------------------------------------------------
// Selective-repeat sender window: window engine
// Holds the window state, grants send requests, records acks, steps the base
// over acknowledged slots one per cycle and drives the result register.
// ----------------------------------------------------------------------------
`include "selective_repeat_sender_window_defines.svh"
`default_nettype none

module srsw_engine #(
  parameter int WINDOW_DEPTH = srsw_pkg::WINDOW_DEPTH_DEF,
  parameter int PAYLOAD_MAX  = srsw_pkg::PAYLOAD_MAX_DEF,
  parameter int SEQ_SPACE    = srsw_pkg::SEQ_SPACE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cmd_vld,
  output      logic                               cmd_rdy,
  input  wire srsw_pkg::cmd_t                     cmd,
  input  wire logic                               cfg_wr_en,
  input  wire logic [srsw_pkg::CFG_W-1:0]         cfg_wr_data,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  output      logic [srsw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output      logic [srsw_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  localparam int SEQ_W  = $clog2(SEQ_SPACE);
  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int STEP_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PLEN_W = $clog2(PAYLOAD_MAX + 1);
  localparam int CMP_W  = (SEQ_W + 1 > 9) ? SEQ_W + 1 : 9;
  localparam int PAD_W  = srsw_pkg::OUT_TDATA_W - srsw_pkg::SEQ_PORT_W
                          - srsw_pkg::SLOT_PORT_W - srsw_pkg::PLEN_PORT_W - 3;

  localparam logic [SEQ_W:0]     SEQ_C     = (SEQ_W + 1)'(SEQ_SPACE);
  localparam logic [SEQ_W-1:0]   SEQ_LAST  = SEQ_W'(SEQ_SPACE - 1);
  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [SLOT_W:0]    SLOT_C    = (SLOT_W + 1)'(WINDOW_DEPTH);
  localparam logic [STEP_W-1:0]  STEP_MAX  = STEP_W'(WINDOW_DEPTH);
  localparam logic [CMP_W-1:0]   WIN_C     = CMP_W'(WINDOW_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ_CHK,
    ST_REQ_ISSUE,
    ST_ACK_CHK,
    ST_ADVANCE,
    ST_FINISH
  } state_t;

  function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] from_s,
                                                input logic [SEQ_W-1:0] to_s);
    logic [SEQ_W:0] sum;
    sum = {1'b0, to_s} + SEQ_C - {1'b0, from_s};
    if (sum >= SEQ_C) begin
      sum = sum - SEQ_C;
    end
    return sum[SEQ_W-1:0];
  endfunction

  state_t                      state_r;
  srsw_pkg::cmd_t              cmd_r;
  logic [SEQ_W-1:0]            base_r;
  logic [SEQ_W-1:0]            next_r;
  logic [SEQ_W-1:0]            final_r;
  logic [SLOT_W-1:0]           base_slot_r;
  logic [SLOT_W-1:0]           next_slot_r;
  logic [WINDOW_DEPTH-1:0]     flags_r;
  logic [srsw_pkg::CFG_W-1:0]  total_r;
  logic [srsw_pkg::CFG_W-1:0]  bytes_r;
  logic [srsw_pkg::CFG_W-1:0]  left_r;
  logic                        all_r;
  logic                        done_r;
  logic [STEP_W-1:0]           steps_r;

  logic                        res_issued_r;
  logic [SEQ_W-1:0]            res_seq_r;
  logic [SLOT_W-1:0]           res_slot_r;
  logic [PLEN_W-1:0]           res_plen_r;
  logic [1:0]                  res_status_r;

  logic                                 out_vld_r;
  logic [srsw_pkg::OUT_TDATA_W-1:0]     out_tdata_r;
  logic [srsw_pkg::OUT_TUSER_W-1:0]     out_tuser_r;

  logic                        next_in_win;
  logic                        base_span_ok;
  logic [SEQ_W-1:0]            ack_seq;
  logic [SEQ_W-1:0]            ack_dist;
  logic                        ack_in_win;
  logic [SLOT_W:0]             slot_sum;
  logic [SLOT_W-1:0]           ack_slot;
  logic [srsw_pkg::CFG_W-1:0]  left_nxt;
  logic                        last_pkt;
  logic [PLEN_W-1:0]           plen;
  logic [SEQ_W-1:0]            next_seq_nxt;
  logic [SLOT_W-1:0]           next_slot_nxt;
  logic [SEQ_W-1:0]            base_nxt;
  logic [SLOT_W-1:0]           base_slot_nxt;
  logic                        adv_go;
  logic                        out_free;
  logic [PLEN_W+srsw_pkg::PLEN_PORT_W-1:0]   plen_ext;
  logic [SLOT_W+srsw_pkg::SLOT_PORT_W-1:0]   slot_ext;

  always_comb begin
    next_in_win  = CMP_W'(seq_dist(base_r, next_r)) < WIN_C;
    base_span_ok = CMP_W'(seq_dist(base_r, next_r)) <= WIN_C;

    ack_seq    = cmd_r.ack[SEQ_W-1:0];
    ack_dist   = seq_dist(base_r, ack_seq);
    ack_in_win = (cmd_r.kind == srsw_pkg::CMD_ACK) && (CMP_W'(ack_dist) < WIN_C);

    // An ack that wrapped past the top of the sequence space sits below the
    // window size, so its own value is already the slot.
    slot_sum = {1'b0, base_slot_r} + (SLOT_W + 1)'(ack_dist);
    if (slot_sum >= SLOT_C) begin
      slot_sum = slot_sum - SLOT_C;
    end
    if (ack_seq < base_r) begin
      ack_slot = SLOT_W'(ack_seq);
    end else begin
      ack_slot = slot_sum[SLOT_W-1:0];
    end

    left_nxt = (total_r > bytes_r) ? total_r - bytes_r : '0;
    last_pkt = left_r <= srsw_pkg::CFG_W'(PAYLOAD_MAX);
    plen     = last_pkt ? PLEN_W'(left_r) : PLEN_W'(PAYLOAD_MAX);

    if (next_r == SEQ_LAST) begin
      next_seq_nxt  = '0;
      next_slot_nxt = '0;
    end else begin
      next_seq_nxt  = next_r + 1'b1;
      next_slot_nxt = (next_slot_r == SLOT_LAST) ? '0 : next_slot_r + 1'b1;
    end
    if (base_r == SEQ_LAST) begin
      base_nxt      = '0;
      base_slot_nxt = '0;
    end else begin
      base_nxt      = base_r + 1'b1;
      base_slot_nxt = (base_slot_r == SLOT_LAST) ? '0 : base_slot_r + 1'b1;
    end

    adv_go   = (steps_r < STEP_MAX) && (base_r != next_r) && flags_r[base_slot_r];
    out_free = !out_vld_r || out_tready;

    plen_ext = (PLEN_W + srsw_pkg::PLEN_PORT_W)'(res_plen_r);
    slot_ext = (SLOT_W + srsw_pkg::SLOT_PORT_W)'(res_slot_r);
  end

  assign cmd_rdy    = state_r == ST_IDLE;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      final_r     <= '0;
      base_slot_r <= '0;
      next_slot_r <= '0;
      flags_r     <= '0;
      total_r     <= '0;
      bytes_r     <= '0;
      all_r       <= 1'b0;
      done_r      <= 1'b0;
      steps_r     <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        total_r <= cfg_wr_data;
      end
      // In ST_FINISH the result register is reloaded below instead.
      if (out_vld_r && out_tready && (state_r != ST_FINISH)) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (cmd_vld) begin
            cmd_r        <= cmd;
            res_issued_r <= 1'b0;
            res_seq_r    <= '0;
            res_slot_r   <= '0;
            res_plen_r   <= '0;
            res_status_r <= srsw_pkg::ACK_NONE;
            steps_r      <= '0;
            state_r      <= (cmd.kind == srsw_pkg::CMD_REQ) ? ST_REQ_CHK : ST_ACK_CHK;
          end
        end
        ST_REQ_CHK: begin
          if (!all_r && next_in_win) begin
            left_r  <= left_nxt;
            state_r <= ST_REQ_ISSUE;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_REQ_ISSUE: begin
          res_issued_r         <= 1'b1;
          res_seq_r            <= next_r;
          res_slot_r           <= next_slot_r;
          res_plen_r           <= plen;
          bytes_r              <= bytes_r + srsw_pkg::CFG_W'(plen);
          flags_r[next_slot_r] <= 1'b0;
          next_r               <= next_seq_nxt;
          next_slot_r          <= next_slot_nxt;
          if (last_pkt) begin
            all_r   <= 1'b1;
            final_r <= next_r;
          end
          state_r <= ST_FINISH;
        end
        ST_ACK_CHK: begin
          if (ack_in_win) begin
            res_status_r      <= flags_r[ack_slot] ? srsw_pkg::ACK_DUP : srsw_pkg::ACK_NEW;
            flags_r[ack_slot] <= 1'b1;
            state_r           <= ST_ADVANCE;
          end else begin
            res_status_r <= srsw_pkg::ACK_OUTSIDE;
            state_r      <= ST_FINISH;
          end
        end
        ST_ADVANCE: begin
          if (adv_go) begin
            flags_r[base_slot_r] <= 1'b0;
            if (all_r && (base_r == final_r)) begin
              done_r <= 1'b1;
            end
            base_r      <= base_nxt;
            base_slot_r <= base_slot_nxt;
            steps_r     <= steps_r + 1'b1;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_vld_r   <= 1'b1;
            out_tdata_r <= {{PAD_W{1'b0}}, done_r, all_r, next_in_win,
                            plen_ext[srsw_pkg::PLEN_PORT_W-1:0],
                            slot_ext[srsw_pkg::SLOT_PORT_W-1:0],
                            srsw_pkg::SEQ_PORT_W'(res_seq_r)};
            out_tuser_r <= {res_status_r, res_issued_r};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `SRSW_ASSERT(a_base_not_past_next, base_span_ok, "window base ran past next sequence")
  `SRSW_ASSERT(a_done_needs_all, done_r |-> all_r, "done raised before final packet issued")
  `SRSW_ASSERT(a_done_sticks, done_r |=> done_r, "done flag dropped")
  `SRSW_ASSERT(a_advance_bounded, (state_r == ST_ADVANCE) |-> (steps_r <= STEP_MAX), "base advance overran window")
  `SRSW_ASSERT(a_issue_moves_next, (state_r == ST_REQ_ISSUE) |=> (next_r != $past(next_r)), "grant did not move next sequence")
  `SRSW_ASSERT_ALWAYS(a_reset_idles, !rst_n |=> (!out_vld_r && (state_r == ST_IDLE)), "reset left engine busy")

endmodule

`default_nettype wire

FILE: hw/rtl/selective_repeat_sender_window.sv
// ----------------------------------------------------------------------------
// Selective-repeat sender window
// Packetises a transfer of total_bytes bytes, hands out sequence numbers and
// window slots to send requests, and tracks acknowledgements over the window.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                                     Carries
//  --------  ---------  ----------------------------------------  -----------------------
//  in_       slave      in_tvalid / in_tready / in_tdata / tuser  send request or ack
//  out_      master     out_tvalid / out_tready / out_tdata/tuser one result per item
//  cfg_      write      cfg_wr_en / cfg_wr_data                   total_bytes register
//
// A granted send request passes through the engine's check, issue and finish
// states; an acknowledgement inside the window passes through the check state,
// the advance state, where the base steps over up to WINDOW_DEPTH acknowledged
// slots, one slot per cycle, and the finish state. A refused request or an
// acknowledgement outside the window goes from the check state to finish.
// The engine works on one item at a time; the front register and a two-entry
// queue keep accepting transfers while it is busy or while a result waits.
// Reset is synchronous and active low; it clears the window, the counters and
// total_bytes.
// A stalled output holds its result and the engine waits before writing the
// next one; the queue then fills and in_tready falls.
//
`default_nettype none

module selective_repeat_sender_window #(
  parameter int WINDOW_DEPTH = srsw_pkg::WINDOW_DEPTH_DEF,
  parameter int PAYLOAD_MAX  = srsw_pkg::PAYLOAD_MAX_DEF,
  parameter int SEQ_SPACE    = srsw_pkg::SEQ_SPACE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // [15:0] ack_number
  input  wire logic [srsw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] action
  input  wire logic                               in_tuser,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // [15:0] sequence_out, [18:16] slot_out, [29:19] payload_length,
  // [30] window_open, [31] all_issued, [32] transfer_done, [39:33] zero
  output      logic [srsw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] packet_issued, [2:1] ack_status
  output      logic [srsw_pkg::OUT_TUSER_W-1:0]   out_tuser,
  input  wire logic                               cfg_wr_en,
  input  wire logic [srsw_pkg::CFG_W-1:0]         cfg_wr_data
);

  // Front register to queue.
  logic           front_vld;
  logic           front_rdy;
  srsw_pkg::cmd_t front_cmd;

  // Queue to engine.
  logic           queue_vld;
  logic           queue_rdy;
  srsw_pkg::cmd_t queue_cmd;

  // The front end only sorts transfers; everything that depends on the
  // window state is decided later in the engine, in order.
  srsw_front #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_vld   (front_vld),
    .cmd       (front_cmd),
    .cmd_rdy   (front_rdy)
  );

  srsw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (front_vld),
    .push_rdy (front_rdy),
    .push_cmd (front_cmd),
    .pop_vld  (queue_vld),
    .pop_rdy  (queue_rdy),
    .pop_cmd  (queue_cmd)
  );

  // The engine owns the window, the byte counters and the result register.
  srsw_engine #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .PAYLOAD_MAX  (PAYLOAD_MAX),
    .SEQ_SPACE    (SEQ_SPACE)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_vld     (queue_vld),
    .cmd_rdy     (queue_rdy),
    .cmd         (queue_cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire
